### src/fbdst_pkg.sv
// Shared types and codes for the frame buffer dirty span tracker.
// No dependencies; every other file imports this package.
package fbdst_pkg;

    // Widest coordinate that any screen size needs (up to 1024)
    localparam int CRD_W = 10;

    // Command codes on the input stream
    localparam logic [2:0] FN_PIXEL = 3'd0;
    localparam logic [2:0] FN_HLINE = 3'd1;
    localparam logic [2:0] FN_VLINE = 3'd2;
    localparam logic [2:0] FN_FILL  = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;
    localparam logic [2:0] FN_TAKE  = 3'd5;

    // Job kinds handed from the front end to the engine
    localparam logic [1:0] K_NOP  = 2'd0;
    localparam logic [1:0] K_DRAW = 2'd1;
    localparam logic [1:0] K_READ = 2'd2;
    localparam logic [1:0] K_TAKE = 2'd3;

    // One classified job: a rectangle walk plus the drawing value
    typedef struct packed {
        logic [1:0]       kind;
        logic [CRD_W-1:0] row_first;
        logic [CRD_W-1:0] row_last;
        logic [CRD_W-1:0] col_first;
        logic [CRD_W-1:0] col_last;
        logic [15:0]      color;
        logic             xr;
    } t_cmd;

endpackage

### src/fbdst_front.sv
// Front end: decodes and clips one command into a rectangle walk job.
// Depends on fbdst_pkg.
module fbdst_front #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic [2:0]          i_func,
    input  logic signed [15:0]  i_x_first,
    input  logic signed [15:0]  i_x_last,
    input  logic signed [15:0]  i_y_first,
    input  logic signed [15:0]  i_y_last,
    input  logic [15:0]         i_color,
    input  logic                i_xor_mode,
    output fbdst_pkg::t_cmd     o_cmd
);
    import fbdst_pkg::*;

    logic               x_on, y_on;
    logic signed [15:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [15:0] x_lo_c, x_hi_c, y_lo_c, y_hi_c;
    logic               h_hit, v_hit;

    // Order and clip both end point pairs
    always_comb begin
        x_on   = (i_x_first >= 0) && (i_x_first < SCREEN_WIDTH);
        y_on   = (i_y_first >= 0) && (i_y_first < SCREEN_HEIGHT);
        x_lo   = (i_x_first < i_x_last) ? i_x_first : i_x_last;
        x_hi   = (i_x_first < i_x_last) ? i_x_last  : i_x_first;
        y_lo   = (i_y_first < i_y_last) ? i_y_first : i_y_last;
        y_hi   = (i_y_first < i_y_last) ? i_y_last  : i_y_first;
        h_hit  = (x_hi >= 0) && (x_lo < SCREEN_WIDTH);
        v_hit  = (y_hi >= 0) && (y_lo < SCREEN_HEIGHT);
        x_lo_c = (x_lo < 0) ? 16'sd0 : x_lo;
        x_hi_c = (x_hi > SCREEN_WIDTH - 1) ? 16'(SCREEN_WIDTH - 1) : x_hi;
        y_lo_c = (y_lo < 0) ? 16'sd0 : y_lo;
        y_hi_c = (y_hi > SCREEN_HEIGHT - 1) ? 16'(SCREEN_HEIGHT - 1) : y_hi;
    end

    // Classify the command
    always_comb begin
        o_cmd.kind      = K_NOP;
        o_cmd.row_first = CRD_W'(i_y_first);
        o_cmd.row_last  = CRD_W'(i_y_first);
        o_cmd.col_first = CRD_W'(i_x_first);
        o_cmd.col_last  = CRD_W'(i_x_first);
        o_cmd.color     = i_color;
        o_cmd.xr        = 1'b0;
        case (i_func)
            FN_PIXEL: begin
                if (x_on && y_on) o_cmd.kind = K_DRAW;
            end
            FN_HLINE: begin
                if (y_on && h_hit) o_cmd.kind = K_DRAW;
                o_cmd.col_first = CRD_W'(x_lo_c);
                o_cmd.col_last  = CRD_W'(x_hi_c);
                o_cmd.xr        = i_xor_mode;
            end
            FN_VLINE: begin
                if (x_on && v_hit) o_cmd.kind = K_DRAW;
                o_cmd.row_first = CRD_W'(y_lo_c);
                o_cmd.row_last  = CRD_W'(y_hi_c);
                o_cmd.xr        = i_xor_mode;
            end
            FN_FILL: begin
                o_cmd.kind      = K_DRAW;
                o_cmd.row_first = '0;
                o_cmd.row_last  = CRD_W'(SCREEN_HEIGHT - 1);
                o_cmd.col_first = '0;
                o_cmd.col_last  = CRD_W'(SCREEN_WIDTH - 1);
            end
            FN_READ: begin
                if (x_on && y_on) o_cmd.kind = K_READ;
            end
            FN_TAKE: begin
                if (y_on) o_cmd.kind = K_TAKE;
            end
            default: o_cmd.kind = K_NOP;
        endcase
    end

endmodule

### src/fbdst_fifo.sv
// Two-entry job queue between the front end and the engine.
// Depends on fbdst_pkg.
module fbdst_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fbdst_pkg::t_cmd i_data,
    output logic            o_full,
    input  logic            i_pop,
    output fbdst_pkg::t_cmd o_data,
    output logic            o_empty
);
    import fbdst_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

### src/fbdst_back.sv
// Engine: walks jobs over the frame memory with one read-modify-write per
// cycle, keeps row flags and span memories. Depends on fbdst_pkg.
module fbdst_back #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  fbdst_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_pixel_value,
    output logic            o_row_dirty,
    output logic [6:0]      o_span_start,
    output logic [6:0]      o_span_end
);
    import fbdst_pkg::*;

    localparam int CW        = $clog2(SCREEN_WIDTH);
    localparam int RW        = $clog2(SCREEN_HEIGHT);
    localparam int MEM_DEPTH = SCREEN_HEIGHT << CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [15:0] r_frame [MEM_DEPTH];
    logic [CW-1:0] r_span_lo [SCREEN_HEIGHT];
    logic [CW-1:0] r_span_hi [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_changed;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_kind;
    logic [RW-1:0] r_row, r_row_end;
    logic [CW-1:0] r_col, r_col_first, r_col_end;
    logic [15:0]   r_color;
    logic          r_xr;

    logic          r_pv, r_plast;
    logic [RW-1:0] r_prow;
    logic [CW-1:0] r_pcol;
    logic [15:0]   r_rdata;
    logic [CW-1:0] r_sdlo, r_sdhi;

    logic          r_acc_v;
    logic [CW-1:0] r_acc_lo, r_acc_hi;

    logic [15:0]   r_res_pix;
    logic          r_res_dirty;
    logic [CW-1:0] r_res_lo, r_res_hi;

    logic          r_o_valid;
    logic [15:0]   r_o_pix;
    logic          r_o_dirty;
    logic [6:0]    r_o_lo, r_o_hi;

    logic          col_end, walk_end, out_free;
    logic [15:0]   nv;
    logic          chg, v_n, draw_cmp, do_widen;
    logic [CW-1:0] lo_n, hi_n, w_lo, w_hi;
    logic          we;
    logic [RW+CW-1:0] waddr;
    logic [15:0]   wdata;

    assign col_end  = (r_col == r_col_end);
    assign walk_end = col_end && (r_row == r_row_end);
    assign out_free = !r_o_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    // Compare stage: new value, change and row span accumulation
    always_comb begin
        nv       = (r_xr && r_rdata == r_color) ? ~r_color : r_color;
        chg      = (nv != r_rdata);
        draw_cmp = r_pv && (r_kind == K_DRAW);
        lo_n     = r_acc_v ? r_acc_lo : r_pcol;
        hi_n     = chg ? r_pcol : r_acc_hi;
        v_n      = r_acc_v || chg;
        do_widen = draw_cmp && r_plast && v_n;
        if (r_changed[r_prow]) begin
            w_lo = (lo_n < r_sdlo) ? lo_n : r_sdlo;
            w_hi = (hi_n > r_sdhi) ? hi_n : r_sdhi;
        end else begin
            w_lo = lo_n;
            w_hi = hi_n;
        end
    end

    // Select the frame write: clearing sweep or changed pixel
    always_comb begin
        if (r_state == S_CLR) begin
            we    = 1'b1;
            waddr = {r_row, r_col};
            wdata = '0;
        end else begin
            we    = draw_cmp && chg;
            waddr = {r_prow, r_pcol};
            wdata = nv;
        end
    end

    // Frame memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) r_frame[waddr] <= wdata;
        r_rdata <= r_frame[{r_row, r_col}];
    end

    // Span memories: registered read at the issue row, write on widen
    always_ff @(posedge i_clk) begin
        if (do_widen) begin
            r_span_lo[r_prow] <= w_lo;
            r_span_hi[r_prow] <= w_hi;
        end
        r_sdlo <= r_span_lo[r_row];
        r_sdhi <= r_span_hi[r_row];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) n_state = (i_cmd.kind == K_NOP) ? S_DONE : S_WALK;
            end
            S_CLR:   if (walk_end) n_state = S_IDLE;
            S_WALK:  if (walk_end) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer, walk counters and issue pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_row       <= '0;
            r_col       <= '0;
            r_row_end   <= RW'(SCREEN_HEIGHT - 1);
            r_col_first <= '0;
            r_col_end   <= CW'(SCREEN_WIDTH - 1);
            r_pv        <= 1'b0;
            r_kind      <= K_NOP;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_WALK);
            if (o_pop) begin
                r_kind      <= i_cmd.kind;
                r_row       <= RW'(i_cmd.row_first);
                r_row_end   <= RW'(i_cmd.row_last);
                r_col       <= CW'(i_cmd.col_first);
                r_col_first <= CW'(i_cmd.col_first);
                r_col_end   <= CW'(i_cmd.col_last);
            end else if (r_state == S_WALK || r_state == S_CLR) begin
                if (col_end) begin
                    r_col <= r_col_first;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Job payload and pipeline tags
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_color <= i_cmd.color;
            r_xr    <= i_cmd.xr;
        end
        r_prow  <= r_row;
        r_pcol  <= r_col;
        r_plast <= col_end;
    end

    // Accumulate changed columns of the current row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_v <= 1'b0;
        end else if (o_pop) begin
            r_acc_v <= 1'b0;
        end else if (draw_cmp) begin
            r_acc_v <= r_plast ? 1'b0 : v_n;
        end
        if (draw_cmp) begin
            r_acc_lo <= lo_n;
            r_acc_hi <= hi_n;
        end
    end

    // Row flags: set on widen, clear on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_changed <= '0;
        end else if (do_widen) begin
            r_changed[r_prow] <= 1'b1;
        end else if (r_pv && r_kind == K_TAKE) begin
            r_changed[r_prow] <= 1'b0;
        end
    end

    // Capture read and take results
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res_pix   <= '0;
            r_res_dirty <= 1'b0;
            r_res_lo    <= '0;
            r_res_hi    <= '0;
        end else if (r_pv && r_kind == K_READ) begin
            r_res_pix <= r_rdata;
        end else if (r_pv && r_kind == K_TAKE && r_changed[r_prow]) begin
            r_res_dirty <= 1'b1;
            r_res_lo    <= r_sdlo;
            r_res_hi    <= r_sdhi;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_pix   <= r_res_pix;
            r_o_dirty <= r_res_dirty;
            r_o_lo    <= 7'(r_res_lo);
            r_o_hi    <= 7'(r_res_hi);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_value = r_o_pix;
    assign o_row_dirty   = r_o_dirty;
    assign o_span_start  = r_o_lo;
    assign o_span_end    = r_o_hi;

endmodule

### src/framebuffer_dirty_span_tracker.sv
// Top level of the frame buffer dirty span tracker.
// Depends on fbdst_pkg, fbdst_front, fbdst_fifo and fbdst_back.
//
//  channel  | dir | handshake                  | payload
//  s_axis   | in  | s_axis_tvalid/..tready     | tdata geometry+color, tuser func
//  m_axis   | out | m_axis_tvalid/..tready     | tdata pixel, dirty flag, span
//
// Each drawing, read or take command walks its clipped rectangle over the single
// frame memory port pair, which does one read-modify-write per cycle. After reset
// a clearing pass over every pixel zeroes the frame; commands queue meanwhile.
// A two-entry queue lets input keep flowing while the engine or output stalls,
// until both entries are full.
module framebuffer_dirty_span_tracker #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] x_first, [31:16] x_last, [47:32] y_first, [63:48] y_last,
    // [79:64] color, [80] xor_mode, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] pixel_value, [16] row_dirty, [23:17] span_start,
    // [30:24] span_end, [31] zero
    output logic [31:0] m_axis_tdata
);
    import fbdst_pkg::*;

    t_cmd        front_cmd, q_cmd;
    logic        q_full, q_empty, q_pop, push;
    logic [15:0] pix;
    logic        dirty;
    logic [6:0]  s_lo, s_hi;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    fbdst_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .i_func    (s_axis_tuser),
        .i_x_first (s_axis_tdata[15:0]),
        .i_x_last  (s_axis_tdata[31:16]),
        .i_y_first (s_axis_tdata[47:32]),
        .i_y_last  (s_axis_tdata[63:48]),
        .i_color   (s_axis_tdata[79:64]),
        .i_xor_mode(s_axis_tdata[80]),
        .o_cmd     (front_cmd)
    );

    fbdst_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (front_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_cmd),
        .o_empty(q_empty)
    );

    fbdst_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_cmd        (q_cmd),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pixel_value(pix),
        .o_row_dirty  (dirty),
        .o_span_start (s_lo),
        .o_span_end   (s_hi)
    );

    assign m_axis_tdata = {1'b0, s_hi, s_lo, dirty, pix};

endmodule

### sim/fbdst_scoreboard.sv
`timescale 1ns / 1ps
// Watches both streams of the frame buffer dirty span tracker and checks every result beat.
// It predicts each beat from a private copy of the frame and dirty state. Depends on fbdst_pkg.
module fbdst_scoreboard #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [87:0] i_cmd_data,
    input  logic [2:0]  i_cmd_func,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [31:0] i_res_data,
    output int          o_err_count,
    output int          o_pending
);
    import fbdst_pkg::*;

    typedef struct packed {
        logic [15:0] pixel;
        logic        dirty;
        logic [6:0]  span_lo;
        logic [6:0]  span_hi;
    } t_report;

    logic [15:0] frame [SCREEN_WIDTH*SCREEN_HEIGHT];
    bit          row_dirty_flag [SCREEN_HEIGHT];
    int          row_lo [SCREEN_HEIGHT];
    int          row_hi [SCREEN_HEIGHT];
    t_report     report_queue [$];

    // Merge a changed column range into a row's dirty span
    function automatic void mark_row(int r, int lo, int hi);
        if (!row_dirty_flag[r]) begin
            row_lo[r] = lo;
            row_hi[r] = hi;
            row_dirty_flag[r] = 1;
        end else begin
            if (lo < row_lo[r]) row_lo[r] = lo;
            if (hi > row_hi[r]) row_hi[r] = hi;
        end
    endfunction

    // Write one line pixel, complementing on a match in XOR mode; report a change
    function automatic bit paint(int r, int c, logic [15:0] col, bit xr);
        logic [15:0] cur;
        logic [15:0] nxt;
        cur = frame[r*SCREEN_WIDTH + c];
        nxt = (xr && cur == col) ? ~col : col;
        if (cur == nxt) return 0;
        frame[r*SCREEN_WIDTH + c] = nxt;
        return 1;
    endfunction

    function automatic t_report apply_command(logic [2:0] fn, logic [87:0] d);
        t_report rep;
        int xa, xb, ya, yb, lo, hi, dmin, dmax, first, last;
        logic [15:0] col;
        bit xr;
        rep = '0;
        xa  = int'($signed(d[15:0]));
        xb  = int'($signed(d[31:16]));
        ya  = int'($signed(d[47:32]));
        yb  = int'($signed(d[63:48]));
        col = d[79:64];
        xr  = d[80];
        case (fn)
            FN_PIXEL: begin
                if (xa >= 0 && xa < SCREEN_WIDTH && ya >= 0 && ya < SCREEN_HEIGHT &&
                    frame[ya*SCREEN_WIDTH + xa] != col) begin
                    frame[ya*SCREEN_WIDTH + xa] = col;
                    mark_row(ya, xa, xa);
                end
            end
            FN_HLINE: begin
                if (ya >= 0 && ya < SCREEN_HEIGHT) begin
                    lo = (xa < xb) ? xa : xb;
                    hi = (xa < xb) ? xb : xa;
                    if (lo < 0) lo = 0;
                    if (hi > SCREEN_WIDTH - 1) hi = SCREEN_WIDTH - 1;
                    dmin = SCREEN_WIDTH;
                    dmax = -1;
                    for (int x = lo; x <= hi; x++) begin
                        if (paint(ya, x, col, xr)) begin
                            if (x < dmin) dmin = x;
                            dmax = x;
                        end
                    end
                    if (dmax >= dmin) mark_row(ya, dmin, dmax);
                end
            end
            FN_VLINE: begin
                if (xa >= 0 && xa < SCREEN_WIDTH) begin
                    lo = (ya < yb) ? ya : yb;
                    hi = (ya < yb) ? yb : ya;
                    if (lo < 0) lo = 0;
                    if (hi > SCREEN_HEIGHT - 1) hi = SCREEN_HEIGHT - 1;
                    for (int y = lo; y <= hi; y++)
                        if (paint(y, xa, col, xr)) mark_row(y, xa, xa);
                end
            end
            FN_FILL: begin
                // Rewrite each row from its first to its last differing pixel
                for (int y = 0; y < SCREEN_HEIGHT; y++) begin
                    first = -1;
                    last  = -1;
                    for (int x = 0; x < SCREEN_WIDTH; x++) begin
                        if (frame[y*SCREEN_WIDTH + x] != col) begin
                            if (first < 0) first = x;
                            last = x;
                        end
                    end
                    if (first >= 0) begin
                        for (int x = first; x <= last; x++) frame[y*SCREEN_WIDTH + x] = col;
                        mark_row(y, first, last);
                    end
                end
            end
            FN_READ: begin
                if (xa >= 0 && xa < SCREEN_WIDTH && ya >= 0 && ya < SCREEN_HEIGHT)
                    rep.pixel = frame[ya*SCREEN_WIDTH + xa];
            end
            FN_TAKE: begin
                if (ya >= 0 && ya < SCREEN_HEIGHT && row_dirty_flag[ya]) begin
                    rep.dirty   = 1'b1;
                    rep.span_lo = row_lo[ya][6:0];
                    rep.span_hi = row_hi[ya][6:0];
                    row_dirty_flag[ya] = 0;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // Clear the model in reset; otherwise check the result beat first,
    // then queue the prediction for a command beat
    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (!i_rst_n) begin
            o_err_count = 0;
            foreach (frame[i]) frame[i] = '0;
            foreach (row_dirty_flag[i]) row_dirty_flag[i] = 0;
            report_queue.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_res_data[15:0], i_res_data[16], i_res_data[23:17], i_res_data[30:24]};
                if (report_queue.size() == 0) begin
                    $error("result beat with no command waiting: tdata %h", i_res_data);
                    o_err_count++;
                end else begin
                    want = report_queue.pop_front();
                    if (got.pixel !== want.pixel) begin
                        $error("pixel_value mismatch: expected %h, actual %h",
                               want.pixel, got.pixel);
                        o_err_count++;
                    end
                    if (got.dirty !== want.dirty) begin
                        $error("row_dirty mismatch: expected %b, actual %b",
                               want.dirty, got.dirty);
                        o_err_count++;
                    end
                    if (got.span_lo !== want.span_lo) begin
                        $error("span_start mismatch: expected %0d, actual %0d",
                               want.span_lo, got.span_lo);
                        o_err_count++;
                    end
                    if (got.span_hi !== want.span_hi) begin
                        $error("span_end mismatch: expected %0d, actual %0d",
                               want.span_hi, got.span_hi);
                        o_err_count++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                report_queue.push_back(apply_command(i_cmd_func, i_cmd_data));
        end
        o_pending = report_queue.size();
    end

endmodule

### sim/framebuffer_dirty_span_tracker_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the frame buffer dirty span tracker.
// Depends on fbdst_pkg, the tracker RTL and fbdst_scoreboard.
module framebuffer_dirty_span_tracker_tb;
    import fbdst_pkg::*;

    localparam int RANDOM_PER_PHASE = 400;
    localparam int CYCLE_LIMIT      = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          err_count;
    int          pending;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          func_count [8];
    int          sent_total;

    framebuffer_dirty_span_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fbdst_scoreboard i_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd_ready (s_axis_tready),
        .i_cmd_data  (s_axis_tdata),
        .i_cmd_func  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Abort on a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver backpressure
    always @(negedge i_clk)
        m_axis_tready = (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= rx_stall_pct);

    // Offer one command beat and hold it until accepted; starts and ends at a falling edge.
    // Ready only moves at a rising edge, so its value at the falling edge decides the next one.
    task automatic send_cmd(logic [2:0] fn, logic [15:0] xa, logic [15:0] xb, logic [15:0] ya,
                            logic [15:0] yb, logic [15:0] col, logic xr);
        bit took;
        took = 1'b0;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {7'd0, xr, col, yb, ya, xb, xa};
        s_axis_tuser  = fn;
        s_axis_tvalid = 1'b1;
        while (!took) begin
            took = s_axis_tready;
            @(negedge i_clk);
        end
        func_count[fn]++;
        sent_total++;
    endtask

    // Hold off the input until every predicted result has come back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly on screen, some just off the edges, a few anywhere in 16 bits
    function automatic logic [15:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(0, 127));
        if (r < 92) return 16'(int'($urandom_range(0, 135)) - 4);
        return 16'($urandom());
    endfunction

    // Near end point, so lines stay short most of the time
    function automatic logic [15:0] pick_end(logic [15:0] a);
        if ($urandom_range(0, 9) < 8) return a + 16'(int'($urandom_range(0, 40)) - 20);
        return pick_coord();
    endfunction

    // A small palette makes skipped writes and XOR matches common
    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hF800;
            3: return 16'h07E0;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_random();
        int r;
        logic [2:0]  fn;
        logic [15:0] xa, ya;
        r = $urandom_range(0, 999);
        if (r < 200)      fn = FN_PIXEL;
        else if (r < 400) fn = FN_HLINE;
        else if (r < 550) fn = FN_VLINE;
        else if (r < 700) fn = FN_READ;
        else if (r < 985) fn = FN_TAKE;
        else if (r < 988) fn = FN_FILL;
        else              fn = 3'($urandom_range(6, 7));
        xa = pick_coord();
        ya = pick_coord();
        send_cmd(fn, xa, pick_end(xa), ya, pick_end(ya), pick_color(), 1'($urandom()));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        sent_total    = 0;
        foreach (func_count[i]) func_count[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: edges, clipping, skips, XOR, fills, reads and takes
        send_cmd(FN_FILL,  16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 1'b1);
        send_cmd(FN_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
        send_cmd(FN_PIXEL, 16'd127, 16'd0, 16'd127, 16'd0, 16'hA5A5, 1'b0);
        send_cmd(FN_PIXEL, 16'd127, 16'd0, 16'd127, 16'd0, 16'hA5A5, 1'b0);
        send_cmd(FN_PIXEL, 16'hFFFF, 16'd0, 16'd5, 16'd0, 16'h1234, 1'b0);
        send_cmd(FN_PIXEL, 16'd128, 16'd0, 16'h7FFF, 16'd0, 16'h1234, 1'b0);
        send_cmd(FN_HLINE, 16'd200, 16'hFFFB, 16'd3, 16'd0, 16'h5555, 1'b0);
        send_cmd(FN_HLINE, 16'd10, 16'd20, 16'd3, 16'd0, 16'h5555, 1'b1);
        send_cmd(FN_HLINE, 16'd200, 16'd300, 16'd4, 16'd0, 16'h5555, 1'b0);
        send_cmd(FN_HLINE, 16'd0, 16'd5, 16'h8000, 16'd0, 16'h5555, 1'b0);
        send_cmd(FN_VLINE, 16'd9, 16'd0, 16'd150, 16'hFFF0, 16'h00FF, 1'b0);
        send_cmd(FN_VLINE, 16'd9, 16'd0, 16'd2, 16'd6, 16'h00FF, 1'b1);
        send_cmd(FN_VLINE, 16'h8000, 16'd0, 16'd2, 16'd6, 16'h00FF, 1'b0);
        send_cmd(FN_READ,  16'd9, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_READ,  16'd15, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_READ,  16'd128, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_TAKE,  16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_TAKE,  16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_TAKE,  16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_cmd(FN_TAKE,  16'd0, 16'd0, 16'd128, 16'd0, 16'd0, 1'b0);
        send_cmd(3'd6,     16'd1, 16'd1, 16'd1, 16'd1, 16'h1111, 1'b1);
        send_cmd(3'd7,     16'd1, 16'd1, 16'd1, 16'd1, 16'h1111, 1'b1);
        send_cmd(FN_FILL,  16'd0, 16'd0, 16'd0, 16'd0, 16'h1234, 1'b1);
        send_cmd(FN_TAKE,  16'd0, 16'd0, 16'd127, 16'd0, 16'd0, 1'b0);
        drain();

        // Random commands over four idle patterns, draining between them
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
                default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random();
            drain();
        end

        rx_stall_pct = 0;
        repeat (20) @(negedge i_clk);
        $display("Sent %0d commands: %0d pixel, %0d hline, %0d vline, %0d fill, %0d read, %0d take,",
                 sent_total, func_count[FN_PIXEL], func_count[FN_HLINE], func_count[FN_VLINE],
                 func_count[FN_FILL], func_count[FN_READ], func_count[FN_TAKE]);
        $display("%0d unused codes, over four idle/backpressure patterns in %0d cycles",
                 func_count[6] + func_count[7], cycle_count);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### framebuffer_dirty_span_tracker.f
src/fbdst_pkg.sv
src/fbdst_front.sv
src/fbdst_fifo.sv
src/fbdst_back.sv
src/framebuffer_dirty_span_tracker.sv
sim/fbdst_scoreboard.sv
sim/framebuffer_dirty_span_tracker_tb.sv
